>>> hdl/pbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbs_pkg;

  localparam logic [31:0] MAX_TICK_GAP_US = 32'd8000;
  localparam logic [15:0] NEAR_ZERO_PHI   = 16'd357;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_IDLE         = 2'd0,
    MODE_WAIT_CAPTURE = 2'd1,
    MODE_WAIT_RELEASE = 2'd2,
    MODE_BALANCE      = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ARM    = 3'd1,
    OP_STOP   = 3'd2,
    OP_ESTOP  = 3'd3,
    OP_REJECT = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_ARMED         = 3'd1,
    EV_CAPTURE_READY = 3'd2,
    EV_CAPTURE_LOST  = 3'd3,
    EV_BALANCE_START = 3'd4,
    EV_BALANCE_END   = 3'd5,
    EV_STOPPED       = 3'd6,
    EV_ESTOP         = 3'd7
  } event_e;

  typedef enum logic [3:0] {
    RSN_NONE          = 4'd0,
    RSN_OVERRUN       = 4'd1,
    RSN_RATE_NOT_RDY  = 4'd2,
    RSN_BETA          = 4'd3,
    RSN_ARM           = 4'd4,
    RSN_TIME          = 4'd5,
    RSN_REJECTED      = 4'd6,
    RSN_USER_STOP     = 4'd7,
    RSN_BUSY          = 4'd8,
    RSN_NO_DOWN_REF   = 4'd9,
    RSN_NO_ZERO       = 4'd10,
    RSN_MOTOR_OFF     = 4'd11,
    RSN_ARM_FAR       = 4'd12
  } reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPTURE_BETA_MAX = 3'd0,
    CFG_CAPTURE_RATE_MAX = 3'd1,
    CFG_CAPTURE_DWELL_US = 3'd2,
    CFG_RELEASE_BETA_MAX = 3'd3,
    CFG_RELEASE_RATE_MIN = 3'd4,
    CFG_BETA_ABORT       = 3'd5,
    CFG_ARM_ABORT        = 3'd6,
    CFG_BALANCE_TIME_US  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [13:0] capture_beta_max;
    logic [14:0] capture_rate_max;
    logic [23:0] capture_dwell_us;
    logic [13:0] release_beta_max;
    logic [14:0] release_rate_min;
    logic [13:0] beta_abort;
    logic [14:0] arm_abort;
    logic [31:0] balance_time_us;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/pendulum_balance_supervisor.sv
// a word accepted is held in the input register, then registered in the result register
// throughput: one word per cycle while the output is not stalled, set by the input register feeding the result register
// the mode state is updated in the same cycle that loads the result register
// reset (rst_ni low, asynchronous) returns to idle, clears timers and the sample count
// and loads the default thresholds; both channels come out of reset empty
`timescale 1ns / 1ps
`default_nettype none

module pendulum_balance_supervisor (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pbs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [2:0]                      in_op_i,
  input  wire logic [31:0]                     in_now_us_i,
  input  wire logic signed [14:0]              in_beta_i,
  input  wire logic signed [15:0]              in_beta_rate_i,
  input  wire logic signed [15:0]              in_phi_i,
  input  wire logic                            in_rate_ready_i,
  input  wire logic                            in_down_ref_ok_i,
  input  wire logic                            in_arm_zero_ok_i,
  input  wire logic                            in_motor_on_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [1:0]                      out_mode_o,
  output      logic [2:0]                      out_event_res_o,
  output      logic [3:0]                      out_reason_o,
  output      logic                            out_run_control_o,
  output      logic                            out_motor_stop_o,
  output      logic                            out_motor_disable_o,
  output      logic [31:0]                     out_sample_count_o,
  output      logic [31:0]                     out_elapsed_us_o
);
  import pbs_pkg::*;

  cfg_t cfg;

  pbs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  logic        s1_valid_q;
  logic [2:0]  s1_op_q;
  logic [31:0] s1_now_q;
  logic [14:0] s1_beta_q;
  logic [15:0] s1_rate_q;
  logic [15:0] s1_phi_q;
  logic        s1_ready_q;
  logic        s1_down_ok_q;
  logic        s1_zero_ok_q;
  logic        s1_motor_q;

  // supervisor state
  mode_e       mode_q, mode_d;
  logic [31:0] last_tick_q, last_tick_d;
  logic [31:0] dwell_q, dwell_d;
  logic [31:0] run_start_q, run_start_d;
  logic [31:0] samples_q, samples_d;

  // result register
  logic        out_valid_q;
  mode_e       out_mode_q;
  event_e      out_event_q, ev_d;
  reason_e     out_reason_q, rsn_d;
  logic        out_run_q, run_d;
  logic        out_mstop_q, mstop_d;
  logic        out_mdis_q, mdis_d;
  logic [31:0] out_samples_q;
  logic [31:0] out_elapsed_q, elapsed_d;

  logic s2_ready;
  logic proc;
  logic in_accept;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign proc       = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s2_ready || !s1_valid_q) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q      <= in_op_i;
      s1_now_q     <= in_now_us_i;
      s1_beta_q    <= in_beta_i;
      s1_rate_q    <= in_beta_rate_i;
      s1_phi_q     <= in_phi_i;
      s1_ready_q   <= in_rate_ready_i;
      s1_down_ok_q <= in_down_ref_ok_i;
      s1_zero_ok_q <= in_arm_zero_ok_i;
      s1_motor_q   <= in_motor_on_i;
    end
  end

  // magnitudes
  logic [14:0] abeta;
  logic [15:0] arate;
  logic [15:0] aphi;

  assign abeta = s1_beta_q[14] ? (~s1_beta_q + 15'd1) : s1_beta_q;
  assign arate = s1_rate_q[15] ? (~s1_rate_q + 16'd1) : s1_rate_q;
  assign aphi  = s1_phi_q[15]  ? (~s1_phi_q + 16'd1)  : s1_phi_q;

  logic [31:0] gap;
  logic [31:0] dwell_new;
  logic [31:0] run_time;
  logic        in_window;
  logic        end_en;
  reason_e     end_rsn;

  assign gap       = s1_now_q - last_tick_q;
  assign dwell_new = (dwell_q == 32'd0) ? s1_now_q : dwell_q;
  assign run_time  = s1_now_q - run_start_q;
  assign in_window = (abeta <= {1'b0, cfg.capture_beta_max}) &&
                     (arate <= {1'b0, cfg.capture_rate_max}) &&
                     (aphi <= NEAR_ZERO_PHI);

  always_comb begin
    mode_d      = mode_q;
    last_tick_d = last_tick_q;
    dwell_d     = dwell_q;
    run_start_d = run_start_q;
    samples_d   = samples_q;
    ev_d        = EV_NONE;
    rsn_d       = RSN_NONE;
    run_d       = 1'b0;
    mstop_d     = 1'b0;
    mdis_d      = 1'b0;
    elapsed_d   = 32'd0;
    end_en      = 1'b0;
    end_rsn     = RSN_NONE;

    case (s1_op_q)
      OP_TICK: begin
        last_tick_d = s1_now_q;
        case (mode_q)
          MODE_WAIT_CAPTURE: begin
            if (s1_ready_q && in_window) begin
              dwell_d = dwell_new;
              if ((s1_now_q - dwell_new) >= {8'd0, cfg.capture_dwell_us}) begin
                mode_d  = MODE_WAIT_RELEASE;
                dwell_d = 32'd0;
                ev_d    = EV_CAPTURE_READY;
              end
            end else begin
              dwell_d = 32'd0;
            end
          end
          MODE_WAIT_RELEASE: begin
            if (s1_ready_q) begin
              if (abeta > {1'b0, cfg.release_beta_max}) begin
                mstop_d = 1'b1;
                mode_d  = MODE_WAIT_CAPTURE;
                dwell_d = 32'd0;
                ev_d    = EV_CAPTURE_LOST;
              end else if (arate >= {1'b0, cfg.release_rate_min}) begin
                mstop_d     = 1'b1;
                samples_d   = 32'd0;
                run_start_d = s1_now_q;
                mode_d      = MODE_BALANCE;
                ev_d        = EV_BALANCE_START;
              end
            end
          end
          MODE_BALANCE: begin
            end_en = 1'b1;
            if (gap > MAX_TICK_GAP_US) begin
              end_rsn = RSN_OVERRUN;
            end else if (!s1_ready_q) begin
              end_rsn = RSN_RATE_NOT_RDY;
            end else if (abeta >= {1'b0, cfg.beta_abort}) begin
              end_rsn = RSN_BETA;
            end else if (aphi >= {1'b0, cfg.arm_abort}) begin
              end_rsn = RSN_ARM;
            end else if (run_time >= cfg.balance_time_us) begin
              end_rsn = RSN_TIME;
            end else begin
              end_en    = 1'b0;
              run_d     = 1'b1;
              samples_d = samples_q + 32'd1;
            end
          end
          default: ;
        endcase
      end
      OP_ARM: begin
        if (mode_q != MODE_IDLE) begin
          rsn_d = RSN_BUSY;
        end else if (!s1_down_ok_q) begin
          rsn_d = RSN_NO_DOWN_REF;
        end else if (!s1_zero_ok_q) begin
          rsn_d = RSN_NO_ZERO;
        end else if (!s1_motor_q) begin
          rsn_d = RSN_MOTOR_OFF;
        end else if (aphi > NEAR_ZERO_PHI) begin
          rsn_d = RSN_ARM_FAR;
        end else begin
          mstop_d = 1'b1;
          dwell_d = 32'd0;
          mode_d  = MODE_WAIT_CAPTURE;
          ev_d    = EV_ARMED;
        end
      end
      OP_STOP: begin
        if (mode_q == MODE_BALANCE) begin
          end_en  = 1'b1;
          end_rsn = RSN_USER_STOP;
        end else begin
          mstop_d = 1'b1;
          mode_d  = MODE_IDLE;
          dwell_d = 32'd0;
          ev_d    = EV_STOPPED;
          rsn_d   = RSN_USER_STOP;
        end
      end
      OP_ESTOP: begin
        mdis_d  = 1'b1;
        mode_d  = MODE_IDLE;
        dwell_d = 32'd0;
        ev_d    = EV_ESTOP;
      end
      OP_REJECT: begin
        if (mode_q == MODE_BALANCE) begin
          end_en  = 1'b1;
          end_rsn = RSN_REJECTED;
        end
      end
      default: ;
    endcase

    if (end_en) begin
      ev_d      = EV_BALANCE_END;
      rsn_d     = end_rsn;
      mstop_d   = 1'b1;
      elapsed_d = run_time;
      mode_d    = MODE_IDLE;
      dwell_d   = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      last_tick_q <= 32'd0;
      dwell_q     <= 32'd0;
      run_start_q <= 32'd0;
      samples_q   <= 32'd0;
    end else if (proc) begin
      mode_q      <= mode_d;
      last_tick_q <= last_tick_d;
      dwell_q     <= dwell_d;
      run_start_q <= run_start_d;
      samples_q   <= samples_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_mode_q    <= mode_d;
      out_event_q   <= ev_d;
      out_reason_q  <= rsn_d;
      out_run_q     <= run_d;
      out_mstop_q   <= mstop_d;
      out_mdis_q    <= mdis_d;
      out_samples_q <= samples_d;
      out_elapsed_q <= elapsed_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_mode_o          = out_mode_q;
  assign out_event_res_o     = out_event_q;
  assign out_reason_o        = out_reason_q;
  assign out_run_control_o   = out_run_q;
  assign out_motor_stop_o    = out_mstop_q;
  assign out_motor_disable_o = out_mdis_q;
  assign out_sample_count_o  = out_samples_q;
  assign out_elapsed_us_o    = out_elapsed_q;

  // state moves only when a word is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> $stable(mode_q) && $stable(samples_q) && $stable(dwell_q))
    else $error("supervisor state changed without a word");

  // control samples are issued only while balancing
  a_run_in_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_run_q |-> out_mode_q == MODE_BALANCE && out_event_q == EV_NONE)
    else $error("run_control outside balance");

  // emergency stop always lands in idle without a motor stop request
  a_estop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_mdis_q |-> out_mode_q == MODE_IDLE && !out_mstop_q &&
                                  out_event_q == EV_ESTOP)
    else $error("emergency stop result inconsistent");

  // a balance end leaves the supervisor idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && ev_d == EV_BALANCE_END |=> mode_q == MODE_IDLE && dwell_q == 32'd0)
    else $error("balance end did not return to idle");

endmodule

`default_nettype wire

>>> hdl/pbs_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module pbs_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pbs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output pbs_pkg::cfg_t                        cfg_o
);
  import pbs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capture_beta_max <= 14'd143;
      cfg_q.capture_rate_max <= 15'd26;
      cfg_q.capture_dwell_us <= 24'd500000;
      cfg_q.release_beta_max <= 14'd573;
      cfg_q.release_rate_min <= 15'd13;
      cfg_q.beta_abort       <= 14'd1430;
      cfg_q.arm_abort        <= 15'd6434;
      cfg_q.balance_time_us  <= 32'd30000000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAPTURE_BETA_MAX: cfg_q.capture_beta_max <= cfg_wdata_i[13:0];
        CFG_CAPTURE_RATE_MAX: cfg_q.capture_rate_max <= cfg_wdata_i[14:0];
        CFG_CAPTURE_DWELL_US: cfg_q.capture_dwell_us <= cfg_wdata_i[23:0];
        CFG_RELEASE_BETA_MAX: cfg_q.release_beta_max <= cfg_wdata_i[13:0];
        CFG_RELEASE_RATE_MIN: cfg_q.release_rate_min <= cfg_wdata_i[14:0];
        CFG_BETA_ABORT:       cfg_q.beta_abort       <= cfg_wdata_i[13:0];
        CFG_ARM_ABORT:        cfg_q.arm_abort        <= cfg_wdata_i[14:0];
        CFG_BALANCE_TIME_US:  cfg_q.balance_time_us  <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> bench/tb_pendulum_balance_supervisor.sv
`timescale 1ns / 1ps

module tb_pendulum_balance_supervisor;
  import pbs_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  localparam logic [2:0] OP_UNUSED_A = 3'd5;
  localparam logic [2:0] OP_UNUSED_C = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic [31:0]        now_us;
    logic signed [14:0] beta;
    logic signed [15:0] beta_rate;
    logic signed [15:0] phi;
    logic               rate_ready;
    logic               down_ref_ok;
    logic               arm_zero_ok;
    logic               motor_on;
  } event_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  ev;
    logic [3:0]  reason;
    logic        run_control;
    logic        motor_stop;
    logic        motor_disable;
    logic [31:0] samples;
    logic [31:0] elapsed;
  } verdict_t;

  class mode_scoreboard;
    logic [31:0] cap_beta, cap_rate, cap_dwell, rel_beta, rel_rate;
    logic [31:0] abort_beta, abort_arm, run_len;
    mode_e       mode;
    logic [31:0] last_tick, dwell_t0, run_t0, samples;
    verdict_t    expected_verdicts[$];
    int          errors, words, checked;
    int          ev_count[8];
    int          end_count[16];

    function new();
      cap_beta   = 32'd143;
      cap_rate   = 32'd26;
      cap_dwell  = 32'd500000;
      rel_beta   = 32'd573;
      rel_rate   = 32'd13;
      abort_beta = 32'd1430;
      abort_arm  = 32'd6434;
      run_len    = 32'd30000000;
      mode       = MODE_IDLE;
      last_tick  = '0;
      dwell_t0   = '0;
      run_t0     = '0;
      samples    = '0;
      errors     = 0;
      words      = 0;
      checked    = 0;
      foreach (ev_count[i]) ev_count[i] = 0;
      foreach (end_count[i]) end_count[i] = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_CAPTURE_BETA_MAX: cap_beta = val & 32'h3FFF;
        CFG_CAPTURE_RATE_MAX: cap_rate = val & 32'h7FFF;
        CFG_CAPTURE_DWELL_US: cap_dwell = val & 32'hFF_FFFF;
        CFG_RELEASE_BETA_MAX: rel_beta = val & 32'h3FFF;
        CFG_RELEASE_RATE_MIN: rel_rate = val & 32'h7FFF;
        CFG_BETA_ABORT:       abort_beta = val & 32'h3FFF;
        CFG_ARM_ABORT:        abort_arm = val & 32'h7FFF;
        default:              run_len = val;
      endcase
    endfunction

    function logic [31:0] magnitude(int x);
      return (x < 0) ? 32'(-x) : 32'(x);
    endfunction

    function verdict_t finish_run(logic [31:0] now, reason_e why);
      verdict_t v;
      v = '0;
      v.ev = EV_BALANCE_END;
      v.reason = why;
      v.motor_stop = 1'b1;
      v.elapsed = now - run_t0;
      mode = MODE_IDLE;
      dwell_t0 = '0;
      end_count[why]++;
      return v;
    endfunction

    function void note_event(event_word_t w);
      verdict_t    v;
      logic [31:0] gap, abeta, arate, aphi;
      v = '0;
      abeta = magnitude(int'(w.beta));
      arate = magnitude(int'(w.beta_rate));
      aphi = magnitude(int'(w.phi));
      words++;
      if (w.op == OP_TICK) begin
        gap = w.now_us - last_tick;
        last_tick = w.now_us;
        case (mode)
          MODE_WAIT_CAPTURE: begin
            if (!w.rate_ready) begin
              dwell_t0 = '0;
            end else if (abeta <= cap_beta && arate <= cap_rate && aphi <= NEAR_ZERO_PHI) begin
              if (dwell_t0 == 0) dwell_t0 = w.now_us;
              if (w.now_us - dwell_t0 >= cap_dwell) begin
                mode = MODE_WAIT_RELEASE;
                dwell_t0 = '0;
                v.ev = EV_CAPTURE_READY;
              end
            end else begin
              dwell_t0 = '0;
            end
          end
          MODE_WAIT_RELEASE: begin
            if (w.rate_ready) begin
              if (abeta > rel_beta) begin
                v.motor_stop = 1'b1;
                mode = MODE_WAIT_CAPTURE;
                dwell_t0 = '0;
                v.ev = EV_CAPTURE_LOST;
              end else if (arate >= rel_rate) begin
                v.motor_stop = 1'b1;
                samples = '0;
                run_t0 = w.now_us;
                mode = MODE_BALANCE;
                v.ev = EV_BALANCE_START;
              end
            end
          end
          MODE_BALANCE: begin
            if (gap > MAX_TICK_GAP_US) v = finish_run(w.now_us, RSN_OVERRUN);
            else if (!w.rate_ready) v = finish_run(w.now_us, RSN_RATE_NOT_RDY);
            else if (abeta >= abort_beta) v = finish_run(w.now_us, RSN_BETA);
            else if (aphi >= abort_arm) v = finish_run(w.now_us, RSN_ARM);
            else if (w.now_us - run_t0 >= run_len) v = finish_run(w.now_us, RSN_TIME);
            else begin
              v.run_control = 1'b1;
              samples = samples + 1;
            end
          end
          default: ;
        endcase
      end else if (w.op == OP_ARM) begin
        if (mode != MODE_IDLE) v.reason = RSN_BUSY;
        else if (!w.down_ref_ok) v.reason = RSN_NO_DOWN_REF;
        else if (!w.arm_zero_ok) v.reason = RSN_NO_ZERO;
        else if (!w.motor_on) v.reason = RSN_MOTOR_OFF;
        else if (aphi > NEAR_ZERO_PHI) v.reason = RSN_ARM_FAR;
        else begin
          v.motor_stop = 1'b1;
          dwell_t0 = '0;
          mode = MODE_WAIT_CAPTURE;
          v.ev = EV_ARMED;
        end
      end else if (w.op == OP_STOP) begin
        if (mode == MODE_BALANCE) begin
          v = finish_run(w.now_us, RSN_USER_STOP);
        end else begin
          v.motor_stop = 1'b1;
          mode = MODE_IDLE;
          dwell_t0 = '0;
          v.ev = EV_STOPPED;
          v.reason = RSN_USER_STOP;
        end
      end else if (w.op == OP_ESTOP) begin
        v.motor_disable = 1'b1;
        mode = MODE_IDLE;
        dwell_t0 = '0;
        v.ev = EV_ESTOP;
      end else if (w.op == OP_REJECT) begin
        if (mode == MODE_BALANCE) v = finish_run(w.now_us, RSN_REJECTED);
      end
      v.mode = mode;
      v.samples = samples;
      ev_count[v.ev]++;
      expected_verdicts.push_back(v);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      checked++;
      compare_field("mode", want.mode, got.mode);
      compare_field("event_res", want.ev, got.ev);
      compare_field("reason", want.reason, got.reason);
      compare_field("run_control", want.run_control, got.run_control);
      compare_field("motor_stop", want.motor_stop, got.motor_stop);
      compare_field("motor_disable", want.motor_disable, got.motor_disable);
      compare_field("sample_count", want.samples, got.samples);
      compare_field("elapsed_us", want.elapsed, got.elapsed);
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]            cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]           cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [2:0]                      in_op_i = '0;
  logic [31:0]                     in_now_us_i = '0;
  logic signed [14:0]              in_beta_i = '0;
  logic signed [15:0]              in_beta_rate_i = '0;
  logic signed [15:0]              in_phi_i = '0;
  logic                            in_rate_ready_i = 1'b0;
  logic                            in_down_ref_ok_i = 1'b0;
  logic                            in_arm_zero_ok_i = 1'b0;
  logic                            in_motor_on_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [1:0]                      out_mode_o;
  logic [2:0]                      out_event_res_o;
  logic [3:0]                      out_reason_o;
  logic                            out_run_control_o;
  logic                            out_motor_stop_o;
  logic                            out_motor_disable_o;
  logic [31:0]                     out_sample_count_o;
  logic [31:0]                     out_elapsed_us_o;

  mode_scoreboard sb;
  logic [31:0]    clock_us = '0;
  bit             calm = 1'b0;
  int             hold_left = 0;
  int             idle_cycles = 0;

  pendulum_balance_supervisor dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_op_i             (in_op_i),
    .in_now_us_i         (in_now_us_i),
    .in_beta_i           (in_beta_i),
    .in_beta_rate_i      (in_beta_rate_i),
    .in_phi_i            (in_phi_i),
    .in_rate_ready_i     (in_rate_ready_i),
    .in_down_ref_ok_i    (in_down_ref_ok_i),
    .in_arm_zero_ok_i    (in_arm_zero_ok_i),
    .in_motor_on_i       (in_motor_on_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_mode_o          (out_mode_o),
    .out_event_res_o     (out_event_res_o),
    .out_reason_o        (out_reason_o),
    .out_run_control_o   (out_run_control_o),
    .out_motor_stop_o    (out_motor_stop_o),
    .out_motor_disable_o (out_motor_disable_o),
    .out_sample_count_o  (out_sample_count_o),
    .out_elapsed_us_o    (out_elapsed_us_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_in(int lo, int hi);
    return (hi <= lo) ? lo : int'($urandom_range(hi, lo));
  endfunction

  function automatic int signed_pick(int lo, int hi, int width);
    int v;
    v = pick_in(lo, hi);
    if ($urandom_range(0, 1) != 0) v = -v;
    if (v >= (1 << (width - 1))) v = -(1 << (width - 1));
    return v;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return pick_in(1, 3);
    if (r < 97) return pick_in(4, 12);
    return pick_in(20, 60);
  endfunction

  function automatic logic [31:0] tick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return 32'($urandom_range(4500, 3500));
    if (r < 94) return 32'($urandom_range(8001, 8000));
    return 32'($urandom_range(1000, 0));
  endfunction

  function automatic logic [2:0] other_op();
    case ($urandom_range(0, 4))
      0: return OP_STOP;
      1: return OP_ESTOP;
      2: return OP_REJECT;
      3: return OP_ARM;
      default: return 3'($urandom_range(OP_UNUSED_C, OP_UNUSED_A));
    endcase
  endfunction

  function automatic event_word_t compose(logic [2:0] op, logic [31:0] now, int beta, int rate,
                                          int phi, logic [3:0] flags);
    event_word_t w;
    w.op = op;
    w.now_us = now;
    w.beta = 15'(beta);
    w.beta_rate = 16'(rate);
    w.phi = 16'(phi);
    {w.rate_ready, w.down_ref_ok, w.arm_zero_ok, w.motor_on} = flags;
    return w;
  endfunction

  // steered by the predicted mode so most words walk a full arm-capture-balance cycle
  function automatic event_word_t make_word();
    event_word_t w;
    logic [31:0] step;
    int          r;
    w = compose(OP_TICK, '0, signed_pick(0, 200, 15), signed_pick(0, 500, 16),
                signed_pick(0, int'(NEAR_ZERO_PHI), 16), 4'b1111);
    step = 32'($urandom_range(200, 0));
    r = $urandom_range(0, 99);
    if (r < 8) begin
      w.op = 3'($urandom);
      w.beta = 15'($urandom);
      w.beta_rate = 16'($urandom);
      w.phi = 16'($urandom);
      {w.rate_ready, w.down_ref_ok, w.arm_zero_ok, w.motor_on} = 4'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        w.now_us = $urandom;
        return w;
      end
      step = tick_step();
    end else begin
      r = $urandom_range(0, 99);
      case (sb.mode)
        MODE_IDLE: begin
          if (r < 70) begin
            w.op = OP_ARM;
          end else if (r < 88) begin
            w.op = OP_ARM;
            case ($urandom_range(0, 3))
              0: w.down_ref_ok = 1'b0;
              1: w.arm_zero_ok = 1'b0;
              2: w.motor_on = 1'b0;
              default: w.phi = 16'(signed_pick(int'(NEAR_ZERO_PHI) + 1, 32768, 16));
            endcase
          end else if (r < 95) begin
            step = tick_step();
          end else begin
            w.op = other_op();
          end
        end
        MODE_WAIT_CAPTURE: begin
          if (r < 80) begin
            w.beta = 15'(signed_pick(0, int'(sb.cap_beta), 15));
            w.beta_rate = 16'(signed_pick(0, int'(sb.cap_rate), 16));
            step = ($urandom_range(0, 99) < 3) ? 32'($urandom_range(1 << 25, 0)) : tick_step();
          end else if (r < 92) begin
            step = tick_step();
            case ($urandom_range(0, 3))
              0: w.rate_ready = 1'b0;
              1: w.beta = 15'(signed_pick(int'(sb.cap_beta) + 1, 16384, 15));
              2: w.beta_rate = 16'(signed_pick(int'(sb.cap_rate) + 1, 32768, 16));
              default: w.phi = 16'(signed_pick(int'(NEAR_ZERO_PHI) + 1, 32768, 16));
            endcase
          end else begin
            w.op = other_op();
          end
        end
        MODE_WAIT_RELEASE: begin
          step = tick_step();
          w.beta = 15'(signed_pick(0, int'(sb.rel_beta), 15));
          if (r < 50) begin
            w.beta_rate = 16'(signed_pick(0, int'(sb.rel_rate) - 1, 16));
            w.rate_ready = ($urandom_range(0, 9) != 0);
          end else if (r < 78) begin
            w.beta_rate = 16'(signed_pick(int'(sb.rel_rate), 32768, 16));
          end else if (r < 92) begin
            w.beta = 15'(signed_pick(int'(sb.rel_beta) + 1, 16384, 15));
          end else begin
            w.op = other_op();
          end
        end
        default: begin
          step = tick_step();
          if (r < 84) begin
            w.beta = 15'(signed_pick(0, int'(sb.abort_beta) - 1, 15));
            w.phi = 16'(signed_pick(0, int'(sb.abort_arm) - 1, 16));
            w.beta_rate = 16'($urandom);
          end else begin
            case ($urandom_range(0, 6))
              0: step = 32'($urandom_range(40000, 8001));
              1: w.rate_ready = 1'b0;
              2: w.beta = 15'(signed_pick(int'(sb.abort_beta), 16384, 15));
              3: w.phi = 16'(signed_pick(int'(sb.abort_arm), 32768, 16));
              4: w.op = OP_REJECT;
              5: w.op = OP_STOP;
              default: w.op = OP_ESTOP;
            endcase
          end
        end
      endcase
    end
    if (w.op != OP_TICK && step > 200) step = 32'($urandom_range(200, 0));
    clock_us = clock_us + step;
    w.now_us = clock_us;
    return w;
  endfunction

  task automatic send_word(input event_word_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_op_i          <= w.op;
    in_now_us_i      <= w.now_us;
    in_beta_i        <= w.beta;
    in_beta_rate_i   <= w.beta_rate;
    in_phi_i         <= w.phi;
    in_rate_ready_i  <= w.rate_ready;
    in_down_ref_ok_i <= w.down_ref_ok;
    in_arm_zero_ok_i <= w.arm_zero_ok;
    in_motor_on_i    <= w.motor_on;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(w);
  endtask

  task automatic drain();
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_thresholds(input logic [31:0] cb, cr, dw, rb, rr, ba, aa, bt);
    drain();
    write_reg(CFG_CAPTURE_BETA_MAX, cb);
    write_reg(CFG_CAPTURE_RATE_MAX, cr);
    write_reg(CFG_CAPTURE_DWELL_US, dw);
    write_reg(CFG_RELEASE_BETA_MAX, rb);
    write_reg(CFG_RELEASE_RATE_MIN, rr);
    write_reg(CFG_BETA_ABORT, ba);
    write_reg(CFG_ARM_ABORT, aa);
    write_reg(CFG_BALANCE_TIME_US, bt);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int count);
    repeat (count) send_word(make_word());
    in_valid_i <= 1'b0;
  endtask

  task automatic directed_words();
    send_word(compose(OP_TICK, 32'd0, -16384, -32768, 32767, 4'b0000));
    send_word(compose(OP_ARM, 32'd10, 0, 0, 0, 4'b1011));
    send_word(compose(OP_ARM, 32'd20, 0, 0, 0, 4'b1101));
    send_word(compose(OP_ARM, 32'd30, 0, 0, 0, 4'b1110));
    send_word(compose(OP_ARM, 32'd40, 0, 0, -32768, 4'b1111));
    send_word(compose(OP_ARM, 32'd50, 0, 0, 358, 4'b1111));
    send_word(compose(OP_ARM, 32'd60, 0, 0, -357, 4'b1111));
    send_word(compose(OP_ARM, 32'd70, 0, 0, 0, 4'b1111));
    // window opening at time zero does not start the dwell timer
    send_word(compose(OP_TICK, 32'd0, 143, -26, 357, 4'b1111));
    send_word(compose(OP_TICK, 32'd4000, -143, 26, -357, 4'b1111));
    send_word(compose(OP_TICK, 32'd504000, 0, 0, 0, 4'b1111));
    send_word(compose(OP_REJECT, 32'd504100, 0, 0, 0, 4'b1111));
    send_word(compose(OP_TICK, 32'd508000, 573, 12, 0, 4'b1111));
    send_word(compose(OP_TICK, 32'd512000, -573, -13, 0, 4'b1111));
    send_word(compose(OP_TICK, 32'd520000, 1429, 0, 6433, 4'b1111));
    send_word(compose(OP_TICK, 32'd528001, 0, 0, 0, 4'b1111));
    send_word(compose(OP_UNUSED_C, 32'hFFFF_FFFF, 16383, 32767, -32768, 4'b1111));
    send_word(compose(OP_STOP, 32'd530000, 0, 0, 0, 4'b1111));
    send_word(compose(OP_ARM, 32'd530100, 0, 0, 0, 4'b1111));
    send_word(compose(OP_ESTOP, 32'd530200, 0, 0, 0, 4'b0000));
    send_word(compose(OP_UNUSED_A, 32'd530300, 0, 0, 0, 4'b1111));
    send_word(compose(OP_UNUSED_A + 3'd1, 32'd530400, 0, 0, 0, 4'b1111));
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_verdict({out_mode_o, out_event_res_o, out_reason_o, out_run_control_o,
                        out_motor_stop_o, out_motor_disable_o, out_sample_count_o,
                        out_elapsed_us_o});
    end
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= 1'b0;
      hold_left = idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $error("no word moved for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_words();

    clock_us = 32'd600000;
    calm = 1'b1;
    set_thresholds(143, 26, 12000, 573, 13, 1430, 6434, 60000);
    run_phase(200);
    calm = 1'b0;

    set_thresholds(12868, 32767, 0, 12868, 32767, 12868, 32767, 32'hFFFF_FFFF);
    run_phase(180);

    set_thresholds(0, 0, 0, 0, 0, 0, 0, 0);
    run_phase(120);

    repeat (2) begin
      set_thresholds($urandom_range(12868, 0), $urandom_range(32767, 0),
                     $urandom_range(40000, 0), $urandom_range(12868, 0),
                     $urandom_range(32767, 0), $urandom_range(12868, 0),
                     $urandom_range(32767, 0), $urandom_range(120000, 0));
      clock_us = $urandom;
      run_phase(200);
    end

    set_thresholds(143, 26, 32'hFF_FFFF, 573, 13, 1430, 6434, 100000);
    run_phase(120);

    // timestamps cross the 32-bit wrap
    set_thresholds(300, 200, 8000, 800, 100, 2000, 8000, 40000);
    clock_us = 32'hFFFF_8000;
    run_phase(200);

    drain();
    $display("%0d event words sent, %0d result words checked; %0d armed, %0d captures,",
             sb.words, sb.checked, sb.ev_count[EV_ARMED], sb.ev_count[EV_CAPTURE_READY]);
    $display("%0d balance runs ended (overrun %0d, rate %0d, beta %0d, arm %0d, time %0d).",
             sb.ev_count[EV_BALANCE_END], sb.end_count[RSN_OVERRUN],
             sb.end_count[RSN_RATE_NOT_RDY], sb.end_count[RSN_BETA], sb.end_count[RSN_ARM],
             sb.end_count[RSN_TIME]);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
